/* rtl/byte_pipe_fifo_assert.svh */
// Assertion macros shared by the byte pipe RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef BYTE_PIPE_FIFO_ASSERT_SVH
`define BYTE_PIPE_FIFO_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked at every rising clock edge outside reset.
`define BPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never hold outside reset.
`define BPF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BPF_ASSERT(lbl, prop, msg)
`define BPF_NEVER(lbl, cond, msg)
`endif

`endif

/* rtl/bpf_pkg.sv */
// Package of the byte pipe: buffer size, action and status codes, pointer step.
// No dependencies.
`default_nettype none

package bpf_pkg;

  // Buffer size in bytes and derived widths
  localparam int unsigned DEPTH    = 4096;
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW       = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned LEVEL_W  = 13;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_READ     = 2'd1,
    ACT_CLOSE_RD = 2'd2,
    ACT_CLOSE_WR = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_EOF    = 3'd2,
    ST_FULL   = 3'd3,
    ST_BROKEN = 3'd4
  } status_e;

  typedef logic [AW-1:0] ptr_t;
  typedef logic [CW-1:0] cnt_t;

  // Ring pointer step with wrap from the last entry back to zero
  function automatic ptr_t bpf_next(input ptr_t ptr);
    ptr_t nxt;
    if (ptr == ptr_t'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + ptr_t'(1);
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

/* rtl/bpf_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/byte_pipe_fifo.sv */
// Byte pipe top level: ring-buffer FIFO with read-end and write-end open flags.
// Depends on bpf_pkg, bpf_ram and byte_pipe_fifo_assert.svh.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------------------
//   in       | input     | in_valid_i/in_ready_o  | action_i, write_data_i, last_of_call_i
//   out      | output    | out_valid_o/out_ready_i| read_data_o, status_o, fill_level_o,
//            |           |                        | last_of_call_res_o
//
// One result per transaction: the store read is issued at the accepting edge, and the
// output register loads its data from the read stage once the output is free.
// Transactions can enter every cycle while the output register drains; a stalled output
// holds one result plus one in the read stage.
// Reset clears pointers and fill count and opens both ends; the byte store has
// no reset and needs no clearing pass.
`default_nettype none

`include "byte_pipe_fifo_assert.svh"

module byte_pipe_fifo (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      action_i,
  input  wire logic [bpf_pkg::DATA_W-1:0]      write_data_i,
  input  wire logic                            last_of_call_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [bpf_pkg::DATA_W-1:0]      read_data_o,
  output logic      [bpf_pkg::STATUS_W-1:0]    status_o,
  output logic      [bpf_pkg::LEVEL_W-1:0]     fill_level_o,
  output logic                                 last_of_call_res_o
);

  import bpf_pkg::*;

  // Pipe state
  ptr_t rptr_q, rptr_d;
  ptr_t wptr_q, wptr_d;
  cnt_t fill_q, fill_d;
  logic rd_open_q, rd_open_d;
  logic wr_open_q, wr_open_d;

  // Read stage (waiting for store data)
  logic    pend_q, pend_d;
  logic    pend_rd_q;
  status_e pend_status_q;
  cnt_t    pend_fill_q;
  logic    pend_last_q;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_data_q;
  status_e             out_status_q;
  cnt_t                out_fill_q;
  logic                out_last_q;

  // Store access
  logic              ram_we, ram_re;
  logic [DATA_W-1:0] ram_rdata;

  logic    in_acc, out_free, pend_move, rd_ok;
  status_e status_d;

  assign out_free  = !out_valid_q || out_ready_i;
  assign pend_move = pend_q && out_free;
  assign in_ready_o = !pend_q || out_free;
  assign in_acc    = in_valid_i && in_ready_o;

  // Action decode: status, store access, next state
  always_comb begin
    rptr_d    = rptr_q;
    wptr_d    = wptr_q;
    fill_d    = fill_q;
    rd_open_d = rd_open_q;
    wr_open_d = wr_open_q;
    status_d  = ST_OK;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    rd_ok     = 1'b0;
    unique case (action_e'(action_i))
      ACT_WRITE: begin
        if (!wr_open_q || !rd_open_q) begin
          status_d = ST_BROKEN;
        end else if (fill_q >= cnt_t'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          ram_we = in_acc;
          wptr_d = bpf_next(wptr_q);
          fill_d = fill_q + cnt_t'(1);
        end
      end
      ACT_READ: begin
        if (!rd_open_q) begin
          status_d = ST_EOF;
        end else if (fill_q != '0) begin
          rd_ok  = 1'b1;
          ram_re = in_acc;
          rptr_d = bpf_next(rptr_q);
          fill_d = fill_q - cnt_t'(1);
        end else begin
          status_d = wr_open_q ? ST_EMPTY : ST_EOF;
        end
      end
      ACT_CLOSE_RD: rd_open_d = 1'b0;
      ACT_CLOSE_WR: wr_open_d = 1'b0;
      default: status_d = ST_OK;
    endcase
  end

  // Pipe state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q    <= '0;
      wptr_q    <= '0;
      fill_q    <= '0;
      rd_open_q <= 1'b1;
      wr_open_q <= 1'b1;
    end else if (in_acc) begin
      rptr_q    <= rptr_d;
      wptr_q    <= wptr_d;
      fill_q    <= fill_d;
      rd_open_q <= rd_open_d;
      wr_open_q <= wr_open_d;
    end
  end

  // Byte store
  bpf_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wptr_q),
    .wdata_i(write_data_i),
    .re_i   (ram_re),
    .raddr_i(rptr_q),
    .rdata_o(ram_rdata)
  );

  // Read stage control
  always_comb begin
    pend_d = pend_q;
    if (in_acc) begin
      pend_d = 1'b1;
    end else if (pend_move) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_rd_q     <= rd_ok;
      pend_status_q <= status_d;
      pend_fill_q   <= fill_d;
      pend_last_q   <= last_of_call_i;
    end
  end

  // Output register control
  always_comb begin
    out_valid_d = out_valid_q;
    if (pend_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload: store data only on a successful read
  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      out_data_q   <= pend_rd_q ? ram_rdata : '0;
      out_status_q <= pend_status_q;
      out_fill_q   <= pend_fill_q;
      out_last_q   <= pend_last_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign read_data_o        = out_data_q;
  assign status_o           = out_status_q;
  assign fill_level_o       = LEVEL_W'(out_fill_q);
  assign last_of_call_res_o = out_last_q;

  // Checks
  `BPF_NEVER(a_fill_range, fill_q > cnt_t'(DEPTH), "fill count above buffer depth")
  `BPF_ASSERT(a_pend_held, pend_q && !out_free |=> pend_q, "read stage dropped a result")
  `BPF_NEVER(a_broken_cause, rd_open_q && wr_open_q && status_d == ST_BROKEN, "broken, ends open")
  `BPF_ASSERT(a_write_count, ram_we |=> fill_q == $past(fill_q) + cnt_t'(1), "store write without fill increment")

endmodule

`default_nettype wire

/* sim/tb_byte_pipe_fifo.sv */
// Self-checking testbench for the byte pipe FIFO: random and directed write, read and
// close transactions under input and output stalls, checked against a behavioral mirror.
// Depends on bpf_pkg and the byte_pipe_fifo RTL.
`timescale 1ns / 100ps

module tb_byte_pipe_fifo;
  import bpf_pkg::*;

  typedef struct {
    action_e             act;
    logic [DATA_W-1:0]   data;
    logic                last;
  } pipe_op_t;

  typedef struct {
    logic [DATA_W-1:0]   rdata;
    status_e             status;
    logic [LEVEL_W-1:0]  level;
    logic                last;
  } pipe_result_t;

  // Block ports, inputs known from time zero
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           action_i       = ACT_READ;
  logic [DATA_W-1:0]    write_data_i   = '0;
  logic                 last_of_call_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [DATA_W-1:0]    read_data_o;
  logic [STATUS_W-1:0]  status_o;
  logic [LEVEL_W-1:0]   fill_level_o;
  logic                 last_of_call_res_o;

  // Mirror of the pipe state
  logic [DATA_W-1:0]    mirror_bytes [DEPTH];
  ptr_t                 mirror_rd      = '0;
  ptr_t                 mirror_wr      = '0;
  cnt_t                 mirror_fill    = '0;
  logic                 mirror_rd_open = 1'b1;
  logic                 mirror_wr_open = 1'b1;

  pipe_op_t             ops_pending[$];
  pipe_result_t         results_due[$];
  pipe_op_t             next_op;
  pipe_result_t         want;
  int                   snd_idle_pct   = 0;
  int                   rcv_idle_pct   = 0;
  int                   err_cnt        = 0;

  byte_pipe_fifo dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .write_data_i       (write_data_i),
    .last_of_call_i     (last_of_call_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .read_data_o        (read_data_o),
    .status_o           (status_o),
    .fill_level_o       (fill_level_o),
    .last_of_call_res_o (last_of_call_res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one accepted transaction to the mirror and queue its result
  task automatic pipe_apply(input action_e act, input logic [DATA_W-1:0] data,
                            input logic last);
    pipe_result_t res;
    res.rdata  = '0;
    res.status = ST_OK;
    res.last   = last;
    case (act)
      ACT_WRITE: begin
        if (!mirror_wr_open || !mirror_rd_open) begin
          res.status = ST_BROKEN;
        end else if (mirror_fill >= cnt_t'(DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          mirror_bytes[mirror_wr] = data;
          mirror_wr   = (mirror_wr == ptr_t'(DEPTH - 1)) ? '0 : mirror_wr + 1'b1;
          mirror_fill = mirror_fill + 1'b1;
        end
      end
      ACT_READ: begin
        if (!mirror_rd_open) begin
          res.status = ST_EOF;
        end else if (mirror_fill != '0) begin
          res.rdata   = mirror_bytes[mirror_rd];
          mirror_rd   = (mirror_rd == ptr_t'(DEPTH - 1)) ? '0 : mirror_rd + 1'b1;
          mirror_fill = mirror_fill - 1'b1;
        end else begin
          res.status = mirror_wr_open ? ST_EMPTY : ST_EOF;
        end
      end
      ACT_CLOSE_RD: mirror_rd_open = 1'b0;
      default:      mirror_wr_open = 1'b0;
    endcase
    res.level = LEVEL_W'(mirror_fill);
    results_due.push_back(res);
  endtask

  task automatic queue_op(input action_e act, input logic [DATA_W-1:0] data,
                          input logic last);
    pipe_op_t op;
    op.act  = act;
    op.data = data;
    op.last = last;
    ops_pending.push_back(op);
  endtask

  // Software-like calls: runs of writes or reads ending in last_of_call, with some noise
  task automatic queue_random_calls(input int n);
    int      queued;
    int      run_len;
    action_e act;
    queued = 0;
    while (queued < n) begin
      if ($urandom_range(9) == 0) begin
        act = $urandom_range(1) ? ACT_WRITE : ACT_READ;
        queue_op(act, DATA_W'($urandom), 1'($urandom));
        queued++;
      end else begin
        run_len = $urandom_range(12, 1);
        act     = $urandom_range(1) ? ACT_WRITE : ACT_READ;
        for (int i = 0; i < run_len; i++) begin
          queue_op(act, DATA_W'($urandom), i == run_len - 1);
        end
        queued += run_len;
      end
    end
  endtask

  // Wait until every queued transaction is accepted and every result has arrived;
  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (ops_pending.size() != 0 || in_valid_i || results_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Input driver: valid holds until the transaction is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pipe_apply(action_e'(action_i), write_data_i, last_of_call_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (ops_pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          next_op = ops_pending.pop_front();
          in_valid_i     <= 1'b1;
          action_i       <= next_op.act;
          write_data_i   <= next_op.data;
          last_of_call_i <= next_op.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output stall generator
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Result monitor: compare every taken result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: read_data %0h status %0d fill_level %0d",
               read_data_o, status_o, fill_level_o);
        err_cnt++;
      end else begin
        want = results_due.pop_front();
        if (read_data_o !== want.rdata) begin
          $error("read_data: expected %0h, got %0h", want.rdata, read_data_o);
          err_cnt++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_cnt++;
        end
        if (fill_level_o !== want.level) begin
          $error("fill_level: expected %0d, got %0d", want.level, fill_level_o);
          err_cnt++;
        end
        if (last_of_call_res_o !== want.last) begin
          $error("last_of_call_res: expected %0b, got %0b", want.last, last_of_call_res_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus sequence
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender idles lightly, receiver heavily
    snd_idle_pct = 24;
    rcv_idle_pct = 61;
    @(posedge clk_i);

    // Directed: empty read, data extremes, drain back to empty
    queue_op(ACT_READ,  8'h00, 1'b1);
    queue_op(ACT_WRITE, 8'h00, 1'b0);
    queue_op(ACT_WRITE, 8'hFF, 1'b1);
    queue_op(ACT_WRITE, 8'h80, 1'b0);
    queue_op(ACT_WRITE, 8'h7F, 1'b0);
    queue_op(ACT_WRITE, 8'h55, 1'b0);
    queue_op(ACT_WRITE, 8'hAA, 1'b1);
    for (int i = 0; i < 6; i++) begin
      queue_op(ACT_READ, 8'hFF, i == 5);
    end
    queue_op(ACT_READ, 8'h00, 1'b0);
    queue_random_calls(370);
    wait_drained();

    // Swap the stall pressure
    snd_idle_pct = 61;
    rcv_idle_pct = 24;
    queue_random_calls(370);
    wait_drained();

    // Full rate on both sides
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    queue_random_calls(370);
    wait_drained();

    // Shutdown: writer closes first, reader drains to end of file, then reader closes
    snd_idle_pct = 24;
    rcv_idle_pct = 24;
    queue_op(ACT_WRITE,    8'h11, 1'b0);
    queue_op(ACT_WRITE,    8'h22, 1'b0);
    queue_op(ACT_WRITE,    8'h33, 1'b1);
    queue_op(ACT_CLOSE_WR, 8'h00, 1'b1);
    queue_op(ACT_WRITE,    8'h44, 1'b1);
    queue_op(ACT_READ,     8'h00, 1'b0);
    queue_op(ACT_READ,     8'h00, 1'b0);
    queue_op(ACT_READ,     8'h00, 1'b1);
    queue_op(ACT_READ,     8'hFF, 1'b0);
    queue_op(ACT_CLOSE_WR, 8'hFF, 1'b0);
    queue_op(ACT_CLOSE_RD, 8'h00, 1'b1);
    queue_op(ACT_READ,     8'h00, 1'b1);
    queue_op(ACT_WRITE,    8'h5A, 1'b0);
    queue_op(ACT_CLOSE_RD, 8'hFF, 1'b0);
    wait_drained();

    // Let any stray result show up
    repeat (20) @(posedge clk_i);
    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived", results_due.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
